// ----- rtl/core/svr_pkg.sv -----
// ----------------------------------------------------------------------------
// svr_pkg
// Shared types and constants for the stop-and-wait receiver: the item
// layouts of both streams, the queue record, and the codes for actions,
// phases, packet classes, status and configuration registers.
// ----------------------------------------------------------------------------
package svr_pkg;

  // Protocol constants
  localparam int PAYLOAD_MAX  = 1024;
  localparam int HEADER_BYTES = 16;
  localparam int DATA_FLAG    = 1;
  localparam int FIN_FLAG     = 2;

  // Payload length as carried past the header check (valid headers only)
  localparam int PLEN_W = $clog2(PAYLOAD_MAX + 1);
  localparam int WLEN_W = 11;

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Stream widths
  localparam int IN_TDATA_W  = 184;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 88;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_MAGIC = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_LIMIT     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINGER_SLOTS   = 2'd2;

  localparam logic [15:0] MAGIC_RST        = 16'd0;
  localparam logic [6:0]  IDLE_LIMIT_RST   = 7'd100;
  localparam logic [2:0]  LINGER_SLOTS_RST = 3'd4;

  typedef enum logic [1:0] {
    ACT_DATAGRAM = 2'd0,
    ACT_TIMEOUT  = 2'd1,
    ACT_CANCEL   = 2'd2,
    ACT_START    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_LINGER = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CLS_NONE    = 3'd0,
    CLS_INVALID = 3'd1,
    CLS_FOREIGN = 3'd2,
    CLS_NEW     = 3'd3,
    CLS_DUP     = 3'd4,
    CLS_DROPPED = 3'd5,
    CLS_FIN     = 3'd6
  } pkt_class_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_ACTIVE    = 3'd1,
    ST_DONE      = 3'd2,
    ST_TIMEDOUT  = 3'd3,
    ST_CANCELLED = 3'd4
  } status_t;

  // Input tdata layout, first field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic        checksum_ok;
    logic [15:0] payload_len;
    logic [31:0] ack_field;
    logic [31:0] seq;
    logic [7:0]  reserved;
    logic [7:0]  flags;
    logic [15:0] magic;
    logic [15:0] frame_len;
    logic [15:0] src_port;
    logic [31:0] src_addr;
  } svr_in_t;

  // Output tdata layout, first field in the lowest bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [31:0]       total_bytes;
    status_t           status;
    pkt_class_t        packet_class;
    logic [WLEN_W-1:0] write_len;
    logic              write_payload;
    logic              ack_fin;
    logic [31:0]       ack_seq;
    logic              send_ack;
  } svr_result_t;

  // Classified item handed from front to back
  typedef struct packed {
    action_t           action;
    logic [31:0]       src_addr;
    logic [15:0]       src_port;
    logic [31:0]       seq;
    logic [PLEN_W-1:0] plen;
    logic              hdr_ok;
    logic              is_fin;
    logic              is_data;
  } svr_item_t;

endpackage

// ----- rtl/core/svr_front.sv -----
// ----------------------------------------------------------------------------
// svr_front
// Front end: unpacks each incoming item, runs the header checks against the
// configured magic value and hands a compact classified record to the queue.
// ----------------------------------------------------------------------------
module svr_front import svr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: src_addr, src_port, frame_len, magic, flags, reserved, seq,
  //        ack_field, payload_len, checksum_ok (lowest bit first)
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // tuser: action
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  logic [15:0]           expected_magic,
  output logic                  push_valid,
  input  logic                  push_ready,
  output svr_item_t             push_item
);

  svr_in_t     fields;
  logic [16:0] frame_sum;
  logic        len_ok;
  logic        flags_ok;
  logic        hdr_ok;

  assign fields = svr_in_t'(in_tdata);

  // Length checks: frame must hold the header plus exactly the payload.
  assign frame_sum = 17'(HEADER_BYTES) + {1'b0, fields.payload_len};
  assign len_ok = (fields.frame_len >= 16'(HEADER_BYTES))
               && (fields.payload_len <= 16'(PAYLOAD_MAX))
               && ({1'b0, fields.frame_len} == frame_sum);

  // Flag combination: exactly data with payload, or exactly FIN without.
  always_comb begin
    flags_ok = 1'b0;
    if (fields.flags == 8'(DATA_FLAG)) begin
      flags_ok = (fields.payload_len != 16'd0);
    end else if (fields.flags == 8'(FIN_FLAG)) begin
      flags_ok = (fields.payload_len == 16'd0);
    end
  end

  assign hdr_ok = len_ok && flags_ok
               && (fields.magic == expected_magic)
               && (fields.reserved == 8'd0)
               && (fields.ack_field == 32'd0)
               && fields.checksum_ok;

  // Classified record for the back end.
  always_comb begin
    push_item.action   = action_t'(in_tuser);
    push_item.src_addr = fields.src_addr;
    push_item.src_port = fields.src_port;
    push_item.seq      = fields.seq;
    push_item.plen     = fields.payload_len[PLEN_W-1:0];
    push_item.hdr_ok   = hdr_ok;
    push_item.is_fin   = ((fields.flags & 8'(FIN_FLAG)) != 8'd0);
    push_item.is_data  = ((fields.flags & 8'(DATA_FLAG)) != 8'd0);
  end

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

// ----- rtl/core/svr_queue.sv -----
// ----------------------------------------------------------------------------
// svr_queue
// Short first-in first-out queue of classified items between the front and
// the back, so that each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module svr_queue import svr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  svr_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output svr_item_t pop_item
);

  svr_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; entries are only read once written.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/svr_back.sv -----
// ----------------------------------------------------------------------------
// svr_back
// Back end: holds the transfer state, applies one classified item per cycle
// while its output register is not stalled, and presents the result there.
// ----------------------------------------------------------------------------
module svr_back import svr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  svr_item_t              pop_item,
  input  logic [6:0]             idle_limit,
  input  logic [2:0]             linger_slots,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: send_ack, ack_seq, ack_fin, write_payload, write_len,
  //        packet_class, status, total_bytes (lowest bit first)
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [31:0] expected_seq_r;
  logic [31:0] expected_seq_nxt;
  logic        peer_valid_r;
  logic        peer_valid_nxt;
  logic [31:0] peer_addr_r;
  logic [31:0] peer_addr_nxt;
  logic [15:0] peer_port_r;
  logic [15:0] peer_port_nxt;
  logic [6:0]  idle_count_r;
  logic [6:0]  idle_count_nxt;
  logic [2:0]  linger_left_r;
  logic [2:0]  linger_left_nxt;
  logic [31:0] byte_total_r;
  logic [31:0] byte_total_nxt;

  logic                   out_tvalid_r;
  logic                   out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  svr_result_t            res;

  logic        fire;
  logic        peer_match;
  logic        seq_eq;
  logic        seq_lt;
  logic [6:0]  idle_inc;
  logic        abort;
  logic        fin_accept;
  logic [2:0]  linger_dec;
  logic [32:0] byte_sum;
  logic [15:0] plen16;

  assign pop_ready = !out_tvalid_r || out_tready;
  assign fire      = pop_valid && pop_ready;

  // Shared decode of the current item against the held state.
  assign peer_match = (pop_item.src_addr == peer_addr_r)
                   && (pop_item.src_port == peer_port_r);
  assign seq_eq     = (pop_item.seq == expected_seq_r);
  assign seq_lt     = (pop_item.seq < expected_seq_r);
  assign idle_inc   = idle_count_r + 7'd1;
  assign abort      = (idle_inc >= idle_limit) || (idle_inc == 7'd0);
  assign fin_accept = pop_item.hdr_ok && !(peer_valid_r && !peer_match)
                   && pop_item.is_fin && seq_eq;
  assign linger_dec = (linger_left_r != 3'd0) ? linger_left_r - 3'd1 : 3'd0;
  assign plen16     = 16'(pop_item.plen);
  assign byte_sum   = {1'b0, byte_total_r} + 33'(plen16);

  // Phase transitions.
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (pop_item.action == ACT_START) begin
        phase_nxt = PH_ACTIVE;
      end else begin
        case (phase_r)
          PH_ACTIVE: begin
            case (pop_item.action)
              ACT_CANCEL:  phase_nxt = PH_IDLE;
              ACT_TIMEOUT: if (abort) phase_nxt = PH_IDLE;
              default: begin
                if (fin_accept) begin
                  phase_nxt = (linger_slots != 3'd0) ? PH_LINGER : PH_IDLE;
                end
              end
            endcase
          end
          PH_LINGER: begin
            if (pop_item.action == ACT_CANCEL || linger_dec == 3'd0) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Result fields and the remaining state.
  always_comb begin
    expected_seq_nxt = expected_seq_r;
    peer_valid_nxt   = peer_valid_r;
    peer_addr_nxt    = peer_addr_r;
    peer_port_nxt    = peer_port_r;
    idle_count_nxt   = idle_count_r;
    linger_left_nxt  = linger_left_r;
    byte_total_nxt   = byte_total_r;

    res               = '0;
    res.packet_class  = CLS_NONE;
    res.status        = ST_IDLE;

    if (fire) begin
      if (pop_item.action == ACT_START) begin
        expected_seq_nxt = '0;
        peer_valid_nxt   = 1'b0;
        peer_addr_nxt    = '0;
        peer_port_nxt    = '0;
        idle_count_nxt   = '0;
        linger_left_nxt  = '0;
        byte_total_nxt   = '0;
        res.status       = ST_ACTIVE;
      end else begin
        case (phase_r)
          PH_ACTIVE: begin
            res.status = ST_ACTIVE;
            case (pop_item.action)
              ACT_CANCEL: res.status = ST_CANCELLED;
              ACT_TIMEOUT: begin
                idle_count_nxt = idle_inc;
                if (abort) res.status = ST_TIMEDOUT;
              end
              default: begin
                idle_count_nxt = '0;
                if (!pop_item.hdr_ok) begin
                  res.packet_class = CLS_INVALID;
                end else if (peer_valid_r && !peer_match) begin
                  res.packet_class = CLS_FOREIGN;
                end else begin
                  // First valid sender becomes the peer.
                  if (!peer_valid_r) begin
                    peer_valid_nxt = 1'b1;
                    peer_addr_nxt  = pop_item.src_addr;
                    peer_port_nxt  = pop_item.src_port;
                  end
                  if (pop_item.is_fin) begin
                    if (seq_eq) begin
                      res.send_ack     = 1'b1;
                      res.ack_seq      = pop_item.seq;
                      res.ack_fin      = 1'b1;
                      res.packet_class = CLS_FIN;
                      res.status       = ST_DONE;
                      linger_left_nxt  = linger_slots;
                    end else begin
                      res.packet_class = CLS_DROPPED;
                    end
                  end else if (!pop_item.is_data) begin
                    res.packet_class = CLS_DROPPED;
                  end else if (seq_eq) begin
                    // In-order data: deliver, count and advance.
                    res.write_payload = 1'b1;
                    res.write_len     = plen16[WLEN_W-1:0];
                    res.send_ack      = 1'b1;
                    res.ack_seq       = pop_item.seq;
                    res.packet_class  = CLS_NEW;
                    byte_total_nxt    = byte_sum[32] ? '1 : byte_sum[31:0];
                    expected_seq_nxt  = expected_seq_r + 32'd1;
                  end else if (seq_lt) begin
                    res.send_ack     = 1'b1;
                    res.ack_seq      = pop_item.seq;
                    res.packet_class = CLS_DUP;
                  end else begin
                    res.packet_class = CLS_DROPPED;
                  end
                end
              end
            endcase
          end
          PH_LINGER: begin
            res.status = ST_DONE;
            if (pop_item.action == ACT_CANCEL) begin
              linger_left_nxt = '0;
            end else begin
              if (pop_item.action == ACT_DATAGRAM) begin
                if (!peer_valid_r || !peer_match) begin
                  res.packet_class = CLS_FOREIGN;
                end else if (!pop_item.hdr_ok) begin
                  res.packet_class = CLS_INVALID;
                end else if (pop_item.is_fin && seq_eq) begin
                  res.send_ack     = 1'b1;
                  res.ack_seq      = pop_item.seq;
                  res.ack_fin      = 1'b1;
                  res.packet_class = CLS_FIN;
                end else begin
                  res.packet_class = CLS_DROPPED;
                end
              end
              linger_left_nxt = linger_dec;
            end
          end
          default: res.status = ST_IDLE;
        endcase
      end
    end

    res.total_bytes = byte_total_nxt;
  end

  // Output register: loads on each processed item, clears when taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (fire) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      expected_seq_r <= '0;
      peer_valid_r   <= 1'b0;
      peer_addr_r    <= '0;
      peer_port_r    <= '0;
      idle_count_r   <= '0;
      linger_left_r  <= '0;
      byte_total_r   <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      expected_seq_r <= expected_seq_nxt;
      peer_valid_r   <= peer_valid_nxt;
      peer_addr_r    <= peer_addr_nxt;
      peer_port_r    <= peer_port_nxt;
      idle_count_r   <= idle_count_nxt;
      linger_left_r  <= linger_left_nxt;
      byte_total_r   <= byte_total_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= OUT_TDATA_W'(res);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- rtl/core/stop_and_wait_receiver.sv -----
// ----------------------------------------------------------------------------
// stop_and_wait_receiver
// Receiver side of a stop-and-wait transfer: header checks, peer lock,
// in-order delivery, acknowledgements, FIN linger and idle timeout abort.
// ----------------------------------------------------------------------------
// Every input item (datagram header, timeout, cancel or start) yields exactly
// one result item. While the queue has room the block takes one item per
// clock cycle, and the front end checks a header in the cycle it is accepted;
// the back end updates the transfer state for one item per cycle while the
// output register is empty or being taken. Items pass the four-entry queue,
// then the output register, which absorb stalls on the result side; in_tready
// falls only once the queue is full. There is no start-up pass after reset.
// Configuration registers may be written only while no items are in flight.
// ----------------------------------------------------------------------------
module stop_and_wait_receiver import svr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: src_addr, src_port, frame_len, magic, flags, reserved, seq,
  //        ack_field, payload_len, checksum_ok (lowest bit first)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: action
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: send_ack, ack_seq, ack_fin, write_payload, write_len,
  //        packet_class, status, total_bytes (lowest bit first)
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [15:0] expected_magic_r;
  logic [15:0] expected_magic_nxt;
  logic [6:0]  idle_limit_r;
  logic [6:0]  idle_limit_nxt;
  logic [2:0]  linger_slots_r;
  logic [2:0]  linger_slots_nxt;

  logic        push_valid;
  logic        push_ready;
  svr_item_t   push_item;
  logic        pop_valid;
  logic        pop_ready;
  svr_item_t   pop_item;

  // Configuration registers; writes beyond the register list are ignored.
  always_comb begin
    expected_magic_nxt = expected_magic_r;
    idle_limit_nxt     = idle_limit_r;
    linger_slots_nxt   = linger_slots_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_EXPECTED_MAGIC: expected_magic_nxt = cfg_wdata;
        CFG_IDLE_LIMIT:     idle_limit_nxt     = cfg_wdata[6:0];
        CFG_LINGER_SLOTS:   linger_slots_nxt   = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_magic_r <= MAGIC_RST;
      idle_limit_r     <= IDLE_LIMIT_RST;
      linger_slots_r   <= LINGER_SLOTS_RST;
    end else begin
      expected_magic_r <= expected_magic_nxt;
      idle_limit_r     <= idle_limit_nxt;
      linger_slots_r   <= linger_slots_nxt;
    end
  end

  // Header checks and classification.
  svr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .expected_magic (expected_magic_r),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // Queue between the front and back ends.
  svr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Transfer state and result register.
  svr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .idle_limit   (idle_limit_r),
    .linger_slots (linger_slots_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

// ----- rtl/core/svr_checker.sv -----
// ----------------------------------------------------------------------------
// svr_checker
// Port-level checks for the stop-and-wait receiver, bound to the top level.
// ----------------------------------------------------------------------------
module svr_checker import svr_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  svr_result_t res;

  assign res = svr_result_t'(out_tdata);

  // No result is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Delivered data is always acknowledged as new data of an active transfer.
  a_write_acked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.write_payload |->
      res.send_ack && !res.ack_fin && res.packet_class == CLS_NEW
      && res.status == ST_ACTIVE)
    else $error("payload delivered without matching acknowledgement");

  // A FIN result carries a FIN acknowledgement and finished status.
  a_fin_acked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.packet_class == CLS_FIN |->
      res.send_ack && res.ack_fin && !res.write_payload && res.status == ST_DONE)
    else $error("FIN result without FIN acknowledgement");

endmodule

bind stop_and_wait_receiver svr_checker u_svr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/tb_stop_and_wait_receiver.sv -----
// ----------------------------------------------------------------------------
// tb_stop_and_wait_receiver
// Self-checking bench for the stop-and-wait receiver. A behavioral predictor
// tracks the transfer state and works out the result of every accepted item.
// The checker compares each output item field by field against the oldest
// prediction. Stimulus starts with directed transfers and abort paths. It
// then runs mostly well-formed random transfers under several register
// settings, with bursty input and a stalling output. A long output hold-off
// fills the block up so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_receiver;
  import svr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          PRINT_LIMIT = 50;
  localparam logic [31:0] PEER_ADDR   = 32'hC0A8_0A17;
  localparam logic [15:0] PEER_PORT   = 16'd4321;
  localparam logic [7:0]  DATA_FL     = 8'(DATA_FLAG);
  localparam logic [7:0]  FIN_FL      = 8'(FIN_FLAG);

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  stop_and_wait_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted transfer state and register copies.
  logic [15:0]  magic_cfg   = MAGIC_RST;
  logic [6:0]   idle_lim    = IDLE_LIMIT_RST;
  logic [2:0]   linger_cfg  = LINGER_SLOTS_RST;
  phase_t       ph          = PH_IDLE;
  logic [31:0]  exp_seq     = '0;
  logic         peer_locked = 1'b0;
  logic [31:0]  peer_addr   = '0;
  logic [15:0]  peer_port   = '0;
  logic [6:0]   idle_cnt    = '0;
  logic [2:0]   linger_cnt  = '0;
  logic [31:0]  total_q     = '0;

  svr_result_t  pending_results[$];
  int           errors       = 0;
  int           result_count = 0;
  int           cycles       = 0;
  int           burst_left   = 0;
  bit           gaps_on      = 1'b1;
  int           hold_off_len = 0;

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                result_count, name, got_v, want_v));
  endtask

  // Header validity under the current magic setting.
  function automatic bit hdr_valid(svr_in_t h);
    if (h.frame_len < HEADER_BYTES) return 1'b0;
    if (h.magic != magic_cfg) return 1'b0;
    if (h.payload_len > PAYLOAD_MAX) return 1'b0;
    if (h.frame_len != HEADER_BYTES + h.payload_len) return 1'b0;
    if (h.reserved != 0 || h.ack_field != 0) return 1'b0;
    if (h.flags == FIN_FL && h.payload_len != 0) return 1'b0;
    if (h.flags == DATA_FL && h.payload_len == 0) return 1'b0;
    if (h.flags != DATA_FL && h.flags != FIN_FL) return 1'b0;
    return h.checksum_ok;
  endfunction

  // Advance the predicted transfer by one accepted item and queue its result.
  function automatic void advance_transfer(action_t act, svr_in_t h);
    svr_result_t r;
    logic        same_peer;
    logic [32:0] sum;
    r = '0;
    same_peer = peer_locked && h.src_addr == peer_addr && h.src_port == peer_port;
    if (act == ACT_START) begin
      ph          = PH_ACTIVE;
      exp_seq     = '0;
      peer_locked = 1'b0;
      peer_addr   = '0;
      peer_port   = '0;
      idle_cnt    = '0;
      linger_cnt  = '0;
      total_q     = '0;
      r.status    = ST_ACTIVE;
    end else if (ph == PH_ACTIVE) begin
      r.status = ST_ACTIVE;
      if (act == ACT_CANCEL) begin
        ph       = PH_IDLE;
        r.status = ST_CANCELLED;
      end else if (act == ACT_TIMEOUT) begin
        idle_cnt = idle_cnt + 7'd1;
        if (idle_cnt >= idle_lim || idle_cnt == 0) begin
          ph       = PH_IDLE;
          r.status = ST_TIMEDOUT;
        end
      end else begin
        idle_cnt = '0;
        if (!hdr_valid(h)) begin
          r.packet_class = CLS_INVALID;
        end else if (peer_locked && !same_peer) begin
          r.packet_class = CLS_FOREIGN;
        end else begin
          if (!peer_locked) begin
            peer_locked = 1'b1;
            peer_addr   = h.src_addr;
            peer_port   = h.src_port;
          end
          if ((h.flags & FIN_FL) != 0) begin
            if (h.seq == exp_seq) begin
              r.send_ack     = 1'b1;
              r.ack_seq      = h.seq;
              r.ack_fin      = 1'b1;
              r.packet_class = CLS_FIN;
              r.status       = ST_DONE;
              linger_cnt     = linger_cfg;
              ph             = (linger_cnt != 0) ? PH_LINGER : PH_IDLE;
            end else begin
              r.packet_class = CLS_DROPPED;
            end
          end else if ((h.flags & DATA_FL) == 0) begin
            r.packet_class = CLS_DROPPED;
          end else if (h.seq == exp_seq) begin
            // In-order data: deliver, count bytes with saturation, move on.
            r.write_payload = 1'b1;
            r.write_len     = h.payload_len[WLEN_W-1:0];
            sum             = {1'b0, total_q} + h.payload_len;
            total_q         = sum[32] ? '1 : sum[31:0];
            r.send_ack      = 1'b1;
            r.ack_seq       = h.seq;
            exp_seq         = exp_seq + 32'd1;
            r.packet_class  = CLS_NEW;
          end else if (h.seq < exp_seq) begin
            r.send_ack     = 1'b1;
            r.ack_seq      = h.seq;
            r.packet_class = CLS_DUP;
          end else begin
            r.packet_class = CLS_DROPPED;
          end
        end
      end
    end else if (ph == PH_LINGER) begin
      r.status = ST_DONE;
      if (act == ACT_CANCEL) begin
        ph         = PH_IDLE;
        linger_cnt = '0;
      end else begin
        if (act == ACT_DATAGRAM) begin
          if (!same_peer) begin
            r.packet_class = CLS_FOREIGN;
          end else if (!hdr_valid(h)) begin
            r.packet_class = CLS_INVALID;
          end else if ((h.flags & FIN_FL) != 0 && h.seq == exp_seq) begin
            r.send_ack     = 1'b1;
            r.ack_seq      = h.seq;
            r.ack_fin      = 1'b1;
            r.packet_class = CLS_FIN;
          end else begin
            r.packet_class = CLS_DROPPED;
          end
        end
        // Every datagram or timeout in the window uses up one slot.
        if (linger_cnt != 0) linger_cnt = linger_cnt - 3'd1;
        if (linger_cnt == 0) ph = PH_IDLE;
      end
    end
    r.total_bytes = total_q;
    pending_results.push_back(r);
  endfunction

  // A well-formed header under the current magic setting.
  function automatic svr_in_t make_header(logic [31:0] addr, logic [15:0] port,
                                          logic [7:0] flg, logic [31:0] sq,
                                          logic [15:0] plen);
    svr_in_t h;
    h             = '0;
    h.src_addr    = addr;
    h.src_port    = port;
    h.frame_len   = 16'(HEADER_BYTES) + plen;
    h.magic       = magic_cfg;
    h.flags       = flg;
    h.seq         = sq;
    h.payload_len = plen;
    h.checksum_ok = 1'b1;
    return h;
  endfunction

  // Break one header rule at random.
  function automatic svr_in_t corrupt_header(svr_in_t h);
    case ($urandom_range(0, 8))
      0: h.magic = 16'($urandom);
      1: h.frame_len = 16'($urandom);
      2: h.reserved = 8'($urandom_range(1, 255));
      3: h.ack_field = $urandom;
      4: begin
        h.payload_len = 16'($urandom_range(PAYLOAD_MAX + 1, 65535));
        h.frame_len   = 16'(HEADER_BYTES) + h.payload_len;
      end
      5: h.flags = 8'($urandom);
      6: h.checksum_ok = 1'b0;
      7: begin
        h.flags       = FIN_FL;
        h.payload_len = 16'($urandom_range(1, PAYLOAD_MAX));
        h.frame_len   = 16'(HEADER_BYTES) + h.payload_len;
      end
      default: begin
        h.flags       = DATA_FL;
        h.payload_len = '0;
        h.frame_len   = 16'(HEADER_BYTES);
      end
    endcase
    return h;
  endfunction

  // Random item aimed at the predicted state: mostly in-order traffic from
  // the locked peer, with duplicates, early packets, strangers and damage.
  function automatic void random_item(output action_t act, output svr_in_t h);
    int unsigned pick;
    logic [31:0] addr;
    logic [31:0] sq;
    logic [15:0] port;
    logic [15:0] plen;
    bit          fin;
    h          = '0;
    h.src_addr = $urandom;
    h.seq      = $urandom;
    pick = $urandom_range(0, 99);
    if (ph == PH_IDLE) begin
      act = (pick < 80) ? ACT_START : action_t'($urandom_range(0, 2));
    end else if (pick < 2) begin
      act = ACT_START;
    end else if (pick < 5) begin
      act = ACT_CANCEL;
    end else if (pick < 13) begin
      act = ACT_TIMEOUT;
    end else begin
      act = ACT_DATAGRAM;
    end
    if (act != ACT_DATAGRAM) return;
    if (peer_locked && $urandom_range(0, 9) != 0) begin
      addr = peer_addr;
      port = peer_port;
    end else begin
      addr = $urandom;
      port = 16'($urandom);
    end
    fin  = (ph == PH_LINGER) ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 99) < 8);
    pick = $urandom_range(0, 99);
    if (fin) plen = '0;
    else if (pick < 5) plen = 16'(PAYLOAD_MAX);
    else if (pick < 10) plen = 16'($urandom_range(1, PAYLOAD_MAX));
    else plen = 16'($urandom_range(1, 64));
    pick = $urandom_range(0, 99);
    if (pick < 70) sq = exp_seq;
    else if (pick < 82) sq = exp_seq - $urandom_range(1, 3);
    else if (pick < 92) sq = exp_seq + $urandom_range(1, 3);
    else sq = $urandom;
    h = make_header(addr, port, fin ? FIN_FL : DATA_FL, sq, plen);
    if ($urandom_range(0, 99) < 15) h = corrupt_header(h);
  endfunction

  // Offer one item, in bursts with random gaps, and predict it on acceptance.
  // Called and returns at a falling edge.
  task automatic push_item(action_t act, svr_in_t h);
    int gap;
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left != 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= h;
    do @(posedge clk); while (!in_tready);
    advance_transfer(act, h);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three registers on consecutive cycles while the block is idle.
  task automatic load_config(logic [15:0] magic_v, logic [6:0] idle_v, logic [2:0] linger_v);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_EXPECTED_MAGIC;
    cfg_wdata <= magic_v;
    @(negedge clk);
    cfg_addr  <= CFG_IDLE_LIMIT;
    cfg_wdata <= CFG_DATA_W'(idle_v);
    @(negedge clk);
    cfg_addr  <= CFG_LINGER_SLOTS;
    cfg_wdata <= CFG_DATA_W'(linger_v);
    @(negedge clk);
    cfg_we     <= 1'b0;
    magic_cfg  = magic_v;
    idle_lim   = idle_v;
    linger_cfg = linger_v;
  endtask

  // Before any start, datagrams, timeouts and cancels are ignored.
  task automatic test_idle_events();
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, DATA_FL, 32'd0, 16'd8));
    push_item(ACT_TIMEOUT, '0);
    push_item(ACT_CANCEL, '0);
  endtask

  // One transfer with reset settings: delivery, duplicates, early and bad
  // packets, a stranger, the FIN and the linger window that follows it.
  task automatic test_in_order_transfer();
    svr_in_t h;
    push_item(ACT_START, '0);
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, DATA_FL, 32'd0, 16'(PAYLOAD_MAX)));
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, DATA_FL, 32'd1, 16'd1));
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, DATA_FL, 32'd0, 16'd5));
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, DATA_FL, 32'hFFFF_FFFF, 16'd3));
    h = make_header(PEER_ADDR, PEER_PORT, DATA_FL, 32'd2, 16'd4);
    h.reserved = 8'hFF;
    push_item(ACT_DATAGRAM, h);
    h = make_header(PEER_ADDR, PEER_PORT, DATA_FL, 32'd2, 16'hFFFF);
    push_item(ACT_DATAGRAM, h);
    push_item(ACT_DATAGRAM, make_header(~PEER_ADDR, ~PEER_PORT, DATA_FL, 32'd2, 16'd7));
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, FIN_FL, 32'd5, 16'd0));
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, FIN_FL, 32'd2, 16'd0));
    // Inside the linger window.
    push_item(ACT_DATAGRAM, make_header(~PEER_ADDR, PEER_PORT, FIN_FL, 32'd2, 16'd0));
    h = make_header(PEER_ADDR, PEER_PORT, FIN_FL, 32'd2, 16'd0);
    h.checksum_ok = 1'b0;
    push_item(ACT_DATAGRAM, h);
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, FIN_FL, 32'd2, 16'd0));
    push_item(ACT_TIMEOUT, '0);
  endtask

  // Timeout abort, cancel while active and while lingering, and a FIN with
  // no linger slots.
  task automatic test_abort_paths();
    load_config(16'h0000, 7'd0, 3'd1);
    push_item(ACT_START, '0);
    push_item(ACT_TIMEOUT, '0);
    push_item(ACT_START, '0);
    push_item(ACT_CANCEL, '0);
    push_item(ACT_START, '0);
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, FIN_FL, 32'd0, 16'd0));
    push_item(ACT_CANCEL, '0);
    load_config(16'h0000, 7'd1, 3'd0);
    push_item(ACT_START, '0);
    push_item(ACT_DATAGRAM, make_header(PEER_ADDR, PEER_PORT, FIN_FL, 32'd0, 16'd0));
  endtask

  // Random transfers under several register settings, extremes included.
  task automatic test_random_traffic();
    action_t act;
    svr_in_t h;
    int      sent;
    int      run;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: load_config(16'h0000, 7'd127, 3'd7);
        1: load_config(16'hFFFF, 7'd1, 3'd1);
        2: load_config(16'($urandom), 7'd3, 3'd4);
        default: load_config(16'($urandom), 7'd100, 3'd2);
      endcase
      sent = 0;
      while (sent < 155) begin
        if (ph == PH_ACTIVE && $urandom_range(0, 99) < 3) begin
          // A run of timeouts with nothing received in between.
          run = $urandom_range(1, 8);
          repeat (run) push_item(ACT_TIMEOUT, '0);
          sent += run;
        end else begin
          random_item(act, h);
          if (ph != PH_IDLE || act == ACT_START) sent++;
          push_item(act, h);
        end
      end
    end
  endtask

  // The result side holds off for a long stretch while items keep coming.
  task automatic test_output_backpressure();
    action_t act;
    svr_in_t h;
    push_item(ACT_START, '0);
    gaps_on      = 1'b0;
    hold_off_len = 80;
    repeat (24) begin
      random_item(act, h);
      push_item(act, h);
    end
    gaps_on = 1'b1;
  endtask

  // Result-side ready: busy and free stretches, plus requested hold-offs.
  always @(negedge clk) begin : ready_pattern
    int unsigned hold_cnt;
    int unsigned mode_left;
    bit          busy;
    if (hold_off_len != 0) begin
      hold_cnt     = hold_off_len;
      hold_off_len = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        busy      = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      out_tready <= busy ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    svr_result_t got;
    svr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none predicted", result_count));
      end else begin
        want = pending_results.pop_front();
        compare_field("send_ack", got.send_ack, want.send_ack);
        compare_field("ack_seq", got.ack_seq, want.ack_seq);
        compare_field("ack_fin", got.ack_fin, want.ack_fin);
        compare_field("write_payload", got.write_payload, want.write_payload);
        compare_field("write_len", got.write_len, want.write_len);
        compare_field("packet_class", got.packet_class, want.packet_class);
        compare_field("status", got.status, want.status);
        compare_field("total_bytes", got.total_bytes, want.total_bytes);
      end
      result_count++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_events();
    test_in_order_transfer();
    test_abort_paths();
    test_random_traffic();
    test_output_backpressure();
    drain();
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- stop_and_wait_receiver.f -----
rtl/core/svr_pkg.sv
rtl/core/svr_front.sv
rtl/core/svr_queue.sv
rtl/core/svr_back.sv
rtl/core/stop_and_wait_receiver.sv
rtl/core/svr_checker.sv
bench/tb_stop_and_wait_receiver.sv
